// ----- hdl/number_to_english_word_tokens_defines.svh -----
// Assertion macros shared by the checker of number_to_english_word_tokens.
// No dependencies.
`ifndef NUMBER_TO_ENGLISH_WORD_TOKENS_DEFINES_SVH
`define NUMBER_TO_ENGLISH_WORD_TOKENS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define N2E_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define N2E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/n2e_pkg.sv -----
// Shared types and word codes for the number-to-words block.
// No dependencies.
`timescale 1ns / 1ps

package n2e_pkg;

    // word slots per request: four groups of five, plus the lone Zero
    localparam int SLOTS     = 21;
    localparam int ZERO_SLOT = 20;

    localparam logic [4:0] W_ZERO     = 5'd0;
    localparam logic [4:0] W_HUNDRED  = 5'd28;
    localparam logic [4:0] W_THOUSAND = 5'd29;
    localparam logic [4:0] W_MILLION  = 5'd30;
    localparam logic [4:0] W_BILLION  = 5'd31;

    typedef struct packed {
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } t_group;

    // slot order is emission order: bit 0 goes out first
    typedef struct packed {
        logic [SLOTS-1:0]      mask;
        logic [SLOTS-1:0][4:0] words;
    } t_item;

endpackage

// ----- hdl/n2e_div1000.sv -----
// Three-stage divide-by-1000 pipeline with a pass-through tag.
// Depends on nothing but its ports.
`timescale 1ns / 1ps

module n2e_div1000 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [30:0] i_x,
    input  logic [19:0] i_tag,
    output logic        o_stall,
    output logic        o_valid,
    output logic [21:0] o_quo,
    output logic [9:0]  o_rem,
    output logic [19:0] o_tag,
    input  logic        i_stall
);

    // floor(2^40 / 1000): the estimate is at most one short of the true quotient
    localparam logic [30:0] RECIP = 31'd1099511627;

    logic        r_a_v, r_b_v, r_c_v;
    logic [61:0] r_a_prod;
    logic [30:0] r_a_x, r_b_x;
    logic [19:0] r_a_tag, r_b_tag, r_c_tag;
    logic [21:0] r_b_q, r_c_q;
    logic [30:0] r_b_qm;
    logic [9:0]  r_c_rem;

    logic        w_stall_a, w_stall_b, w_stall_c;
    logic [21:0] w_q0;
    logic [10:0] w_diff;
    logic        w_over;
    logic [21:0] n_c_q;
    logic [9:0]  n_c_rem;

    assign w_stall_c = r_c_v && i_stall;
    assign w_stall_b = r_b_v && w_stall_c;
    assign w_stall_a = r_a_v && w_stall_b;

    assign w_q0   = r_a_prod[61:40];
    assign w_diff = 11'(r_b_x - r_b_qm);
    assign w_over = w_diff >= 11'd1000;

    always_comb begin
        n_c_q   = r_b_q;
        n_c_rem = w_diff[9:0];
        if (w_over) begin
            n_c_q   = r_b_q + 22'd1;
            n_c_rem = 10'(w_diff - 11'd1000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (!w_stall_a) r_a_v <= i_valid;
            if (!w_stall_b) r_b_v <= r_a_v;
            if (!w_stall_c) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall_a && i_valid) begin
            r_a_prod <= 62'(i_x) * 62'(RECIP);
            r_a_x    <= i_x;
            r_a_tag  <= i_tag;
        end
        if (!w_stall_b && r_a_v) begin
            r_b_q   <= w_q0;
            r_b_qm  <= 31'(w_q0) * 31'd1000;
            r_b_x   <= r_a_x;
            r_b_tag <= r_a_tag;
        end
        if (!w_stall_c && r_b_v) begin
            r_c_q   <= n_c_q;
            r_c_rem <= n_c_rem;
            r_c_tag <= r_b_tag;
        end
    end

    assign o_stall = w_stall_a;
    assign o_valid = r_c_v;
    assign o_quo   = r_c_q;
    assign o_rem   = r_c_rem;
    assign o_tag   = r_c_tag;

endmodule

// ----- hdl/n2e_front.sv -----
// Front end: splits the number into thousand-groups and digits, then
// classifies which word slots are present. Uses n2e_pkg and n2e_div1000.
`timescale 1ns / 1ps

module n2e_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [30:0]   i_value,
    output logic          o_stall,
    output logic          o_valid,
    output n2e_pkg::t_item o_item,
    input  logic          i_stall
);

    localparam int K_HUN     = 0;
    localparam int K_HUNDRED = 1;
    localparam int K_TENS    = 2;
    localparam int K_ONES    = 3;
    localparam int K_SCALE   = 4;
    localparam int KINDS     = 5;

    localparam logic [3:0][4:0] SCALE_WORD = {n2e_pkg::W_BILLION, n2e_pkg::W_MILLION,
                                              n2e_pkg::W_THOUSAND, n2e_pkg::W_ZERO};

    function automatic n2e_pkg::t_group split_group(input logic [9:0] g);
        n2e_pkg::t_group s;
        logic [9:0]      rest;
        s = '0;
        for (int i = 1; i < 10; i++) begin
            if (g >= 10'(i * 100)) s.hun = 4'(i);
        end
        rest = g - 10'(s.hun) * 10'd100;
        for (int i = 1; i < 10; i++) begin
            if (rest >= 10'(i * 10)) s.ten = 4'(i);
        end
        s.one = 4'(rest - 10'(s.ten) * 10'd10);
        return s;
    endfunction

    logic        d1_valid, d1_stall, d2_valid, d2_stall, d3_valid, d3_stall;
    logic [21:0] d1_quo, d2_quo, d3_quo;
    logic [9:0]  d1_rem, d2_rem, d3_rem;
    logic [19:0] d1_tag, d2_tag, d3_tag;

    logic                     r_d_v, r_e_v;
    n2e_pkg::t_group [3:0]    r_d_grp;
    n2e_pkg::t_item           r_e_item;
    n2e_pkg::t_item           n_item;
    logic                     w_stall_d, w_stall_e;

    // units group first, billions last; the tag carries lower groups along
    n2e_div1000 u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_x     (i_value),
        .i_tag   (20'd0),
        .o_stall (o_stall),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_tag   (d1_tag),
        .i_stall (d1_stall)
    );

    n2e_div1000 u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_valid),
        .i_x     (31'(d1_quo)),
        .i_tag   ({d1_tag[19:10], d1_rem}),
        .o_stall (d1_stall),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_tag   (d2_tag),
        .i_stall (d2_stall)
    );

    n2e_div1000 u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d2_valid),
        .i_x     (31'(d2_quo)),
        .i_tag   ({d2_rem, d2_tag[9:0]}),
        .o_stall (d2_stall),
        .o_valid (d3_valid),
        .o_quo   (d3_quo),
        .o_rem   (d3_rem),
        .o_tag   (d3_tag),
        .i_stall (d3_stall)
    );

    assign w_stall_e = r_e_v && i_stall;
    assign w_stall_d = r_d_v && w_stall_e;
    assign d3_stall  = w_stall_d;

    always_comb begin
        int b;
        n2e_pkg::t_group grp;
        n_item = '0;
        for (int g = 0; g < 4; g++) begin
            b   = (3 - g) * KINDS;
            grp = r_d_grp[g];
            n_item.words[5'(b + K_HUN)]     = {1'b0, grp.hun};
            n_item.mask[5'(b + K_HUN)]      = grp.hun != 4'd0;
            n_item.words[5'(b + K_HUNDRED)] = n2e_pkg::W_HUNDRED;
            n_item.mask[5'(b + K_HUNDRED)]  = grp.hun != 4'd0;
            // a ten digit of one makes a teens word that swallows the ones
            n_item.words[5'(b + K_TENS)]    = (grp.ten == 4'd1) ? 5'(grp.one) + 5'd10
                                                                : 5'(grp.ten) + 5'd18;
            n_item.mask[5'(b + K_TENS)]     = grp.ten != 4'd0;
            n_item.words[5'(b + K_ONES)]    = 5'(grp.one);
            n_item.mask[5'(b + K_ONES)]     = (grp.one != 4'd0) && (grp.ten != 4'd1);
            n_item.words[5'(b + K_SCALE)]   = SCALE_WORD[2'(g)];
            n_item.mask[5'(b + K_SCALE)]    = (g != 0) && (grp != '0);
        end
        n_item.words[n2e_pkg::ZERO_SLOT] = n2e_pkg::W_ZERO;
        n_item.mask[n2e_pkg::ZERO_SLOT]  = r_d_grp == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            if (!w_stall_d) r_d_v <= d3_valid;
            if (!w_stall_e) r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall_d && d3_valid) begin
            r_d_grp[3] <= split_group(d3_quo[9:0]);
            r_d_grp[2] <= split_group(d3_rem);
            r_d_grp[1] <= split_group(d3_tag[19:10]);
            r_d_grp[0] <= split_group(d3_tag[9:0]);
        end
        if (!w_stall_e && r_d_v) r_e_item <= n_item;
    end

    assign o_valid = r_e_v;
    assign o_item  = r_e_item;

endmodule

// ----- hdl/n2e_fifo.sv -----
// Four-entry request queue between front and back end.
// Uses n2e_pkg for the entry type.
`timescale 1ns / 1ps

module n2e_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  n2e_pkg::t_item i_item,
    output logic           o_stall,
    output logic           o_valid,
    output n2e_pkg::t_item o_item,
    input  logic           i_stall
);

    localparam int DEPTH = 4;

    n2e_pkg::t_item r_mem [DEPTH];
    logic [1:0]     r_wr, r_rd;
    logic [2:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_stall = r_cnt == 3'(DEPTH);
    assign o_valid = r_cnt != 3'd0;
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 2'd1;
            if (w_pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(w_push) - 3'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_item;
    end

    assign o_item = r_mem[r_rd];

endmodule

// ----- hdl/n2e_back.sv -----
// Back end: walks the present word slots of one request, one word per cycle
// while the output is not stalled, into the output register. Uses n2e_pkg.
`timescale 1ns / 1ps

module n2e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  n2e_pkg::t_item i_item,
    output logic           o_stall,
    output logic           o_valid,
    output logic [4:0]     o_word_code,
    output logic           o_last_word,
    input  logic           i_stall
);

    logic [n2e_pkg::SLOTS-1:0]      r_mask;
    logic [n2e_pkg::SLOTS-1:0][4:0] r_words;
    logic                           r_out_v;
    logic [4:0]                     r_out_word;
    logic                           r_out_last;

    logic [n2e_pkg::SLOTS-1:0] w_low, w_rest;
    logic [4:0]                w_word;
    logic                      w_free, w_have, w_emit, w_take, w_done;

    assign w_free = !r_out_v || !i_stall;
    assign w_have = r_mask != '0;
    assign w_low  = r_mask & (~r_mask + n2e_pkg::SLOTS'(1));
    assign w_rest = r_mask & ~w_low;
    assign w_done = w_rest == '0;
    assign w_emit = w_free && w_have;
    // next request may load as the current one hands over its final word
    assign w_take  = !w_have || (w_emit && w_done);
    assign o_stall = !w_take;

    always_comb begin
        w_word = '0;
        for (int i = 0; i < n2e_pkg::SLOTS; i++) begin
            w_word = w_word | (r_words[i] & {5{w_low[i]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (w_take && i_valid) r_mask <= i_item.mask;
            else if (w_emit)       r_mask <= w_rest;
            if (w_free)            r_out_v <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_valid) r_words <= i_item.words;
        if (w_emit) begin
            r_out_word <= w_word;
            r_out_last <= w_done;
        end
    end

    assign o_valid     = r_out_v;
    assign o_word_code = r_out_word;
    assign o_last_word = r_out_last;

endmodule

// ----- hdl/number_to_english_word_tokens.sv -----
// Top level: number to English word codes. Instantiates n2e_front,
// n2e_fifo and n2e_back; types from n2e_pkg.
//
//  channel | dir | ports                                     | taken when
//  number  | in  | i_valid, i_value, o_stall                 | i_valid && !o_stall
//  word    | out | o_valid, o_word_code, o_last_word, i_stall | o_valid && !i_stall
//
// Output runs at one word per cycle while the receiver does not stall: a number
// spells into 1 to 16 words, and a number already queued follows the last word
// without a gap. The first word reaches the port through three 3-stage
// divide-by-1000 pipelines, digit split, slot classify, the request queue, the
// slot register and the output register.
// Four-entry queue lets the front keep taking numbers while words stall.
// Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps

module number_to_english_word_tokens (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [30:0] i_value,
    output logic        o_stall,
    output logic        o_valid,
    output logic [4:0]  o_word_code,
    output logic        o_last_word,
    input  logic        i_stall
);

    logic           f_valid, f_stall, q_valid, q_stall;
    n2e_pkg::t_item f_item, q_item;

    n2e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_value (i_value),
        .o_stall (o_stall),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_stall (f_stall)
    );

    n2e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_stall (f_stall),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_stall (q_stall)
    );

    n2e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_stall     (q_stall),
        .o_valid     (o_valid),
        .o_word_code (o_word_code),
        .o_last_word (o_last_word),
        .i_stall     (i_stall)
    );

endmodule

// ----- hdl/n2e_checker.sv -----
// Port-level checker for number_to_english_word_tokens, bound to the top.
// Uses n2e_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "number_to_english_word_tokens_defines.svh"

module n2e_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic [4:0]  o_word_code,
    input logic        o_last_word,
    input logic        i_stall
);

    logic       w_in_acc, w_out_acc;
    logic [4:0] r_prev_word;
    logic       r_prev_last, r_seen;
    logic [7:0] r_pending;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_prev_last <= 1'b1;
            r_prev_word <= n2e_pkg::W_ZERO;
            r_pending   <= '0;
        end else begin
            if (w_out_acc) begin
                r_seen      <= 1'b1;
                r_prev_last <= o_last_word;
                r_prev_word <= o_word_code;
            end
            r_pending <= r_pending + 8'(w_in_acc) - 8'(w_out_acc && o_last_word);
        end
    end

    `N2E_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_word_code) && $stable(o_last_word), "stalled word changed")
    `N2E_ASSERT_NOW(a_no_orphan, i_clk, i_rst_n, w_out_acc, r_pending != 8'd0, "word with no number outstanding")
    `N2E_ASSERT_NOW(a_hundred, i_clk, i_rst_n, w_out_acc && o_word_code == n2e_pkg::W_HUNDRED, r_seen && !r_prev_last && r_prev_word >= 5'd1 && r_prev_word <= 5'd9, "Hundred without digit")
    `N2E_ASSERT_NOW(a_zero_alone, i_clk, i_rst_n, w_out_acc && o_word_code == n2e_pkg::W_ZERO, o_last_word && r_prev_last, "Zero not alone")

endmodule

bind number_to_english_word_tokens n2e_checker u_n2e_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking bench for number_to_english_word_tokens: directed and random numbers
// with random sender gaps and receiver stalls, word codes predicted and checked in order.
// Depends on n2e_pkg (word codes) and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [4:0]  W_TWENTY       = 5'd20;
    localparam logic [30:0] VALUE_MAX      = 31'h7fff_ffff;
    localparam int          RANDOM_ITEMS   = 147;
    localparam int          HOLD_AFTER     = 50;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [30:0] i_value = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [4:0]  o_word_code;
    logic        o_last_word;

    number_to_english_word_tokens dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_word_code (o_word_code),
        .o_last_word (o_last_word),
        .i_stall     (i_stall)
    );

    always #5 i_clk = ~i_clk;

    // numbers waiting to be offered, with the gap drawn for each
    logic [30:0] pend_val_q [$];
    int          pend_gap_q [$];

    // words still owed by the block, oldest first
    logic [4:0]  word_code_q [$];
    logic        word_last_q [$];

    int  num_offered = 0;
    int  num_taken   = 0;
    int  words_taken = 0;
    int  mismatches  = 0;
    int  total_items = 0;
    int  idle_cycles = 0;
    bit  run_done    = 1'b0;
    bit  hold_done   = 1'b0;

    // Spell one number into the word queues.
    function automatic void spell_number(input logic [30:0] num);
        logic [4:0]  codes [0:15];
        logic [4:0]  scale_word;
        int unsigned rest;
        int unsigned div;
        int unsigned grp;
        int unsigned hun;
        int unsigned low2;
        int unsigned tn;
        int unsigned on;
        int          n;
        int          g;
        int          k;
        rest = {1'b0, num};
        n = 0;
        scale_word = n2e_pkg::W_ZERO;
        if (num == 0) begin
            codes[0] = n2e_pkg::W_ZERO;
            n = 1;
        end else begin
            for (g = 3; g >= 0; g--) begin
                case (g)
                    3: begin
                        div = 1000000000;
                        scale_word = n2e_pkg::W_BILLION;
                    end
                    2: begin
                        div = 1000000;
                        scale_word = n2e_pkg::W_MILLION;
                    end
                    1: begin
                        div = 1000;
                        scale_word = n2e_pkg::W_THOUSAND;
                    end
                    default: begin
                        div = 1;
                    end
                endcase
                grp  = rest / div;
                rest = rest % div;
                if (grp != 0) begin
                    hun  = grp / 100;
                    low2 = grp % 100;
                    tn   = low2 / 10;
                    on   = low2 % 10;
                    if (hun != 0) begin
                        codes[n]     = hun[4:0];
                        codes[n + 1] = n2e_pkg::W_HUNDRED;
                        n = n + 2;
                    end
                    if (tn == 1) begin
                        codes[n] = low2[4:0];   // teens are a single word
                        n = n + 1;
                    end else begin
                        if (tn >= 2) begin
                            codes[n] = W_TWENTY + tn[4:0] - 5'd2;
                            n = n + 1;
                        end
                        if (on != 0) begin
                            codes[n] = on[4:0];
                            n = n + 1;
                        end
                    end
                    if (g != 0) begin
                        codes[n] = scale_word;
                        n = n + 1;
                    end
                end
            end
        end
        for (k = 0; k < n; k++) begin
            word_code_q.push_back(codes[k]);
            word_last_q.push_back(k == n - 1);
        end
    endfunction

    // sender: one request at a time, payload held while stalled
    logic [30:0] next_val;
    int          gap_left  = 0;
    bit          have_next = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_value <= '0;
        end else if (!(i_valid && num_taken != num_offered)) begin
            if (!have_next && pend_val_q.size() > 0) begin
                next_val  = pend_val_q.pop_front();
                gap_left  = pend_gap_q.pop_front();
                have_next = 1'b1;
            end
            if (have_next && gap_left == 0) begin
                i_valid     <= 1'b1;
                i_value     <= next_val;
                num_offered = num_offered + 1;
                have_next   = 1'b0;
            end else begin
                if (have_next)
                    gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: fresh stall per word, calm stretches, one long hold-off
    int stall_left = 0;
    int hold_left  = 0;
    int rx_seen    = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!hold_done && num_taken >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (words_taken != rx_seen) begin
                rx_seen = words_taken;
                if ((words_taken / 64) % 3 == 1)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 9);
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // accepted requests feed the prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            spell_number(i_value);
            num_taken = num_taken + 1;
        end
    end

    always @(posedge i_clk) begin
        logic [4:0] exp_code;
        logic       exp_last;
        if (i_rst_n && o_valid && !i_stall) begin
            words_taken = words_taken + 1;
            if (word_code_q.size() == 0) begin
                $error("word %0d arrived with nothing expected", o_word_code);
                mismatches = mismatches + 1;
            end else begin
                exp_code = word_code_q.pop_front();
                exp_last = word_last_q.pop_front();
                if (o_word_code !== exp_code) begin
                    $error("word_code: expected %0d, got %0d", exp_code, o_word_code);
                    mismatches = mismatches + 1;
                end
                if (o_last_word !== exp_last) begin
                    $error("last_word: expected %0d, got %0d", exp_last, o_last_word);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !run_done) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $error("watchdog: nothing accepted for %0d cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic queue_number(input logic [30:0] num, input bit calm);
        pend_val_q.push_back(num);
        pend_gap_q.push_back(calm ? 0 : $urandom_range(0, 9));
        total_items = total_items + 1;
    endtask

    initial begin
        longint unsigned sum;
        int unsigned     grp_b;
        int unsigned     grp_m;
        int unsigned     grp_t;
        int unsigned     grp_u;
        int              i;
        int              pick;
        bit              calm;

        // extremes, each tens/teens branch, zero groups, longest name
        queue_number(31'd0, 1'b0);
        queue_number(31'd1, 1'b0);
        queue_number(31'd9, 1'b0);
        queue_number(31'd10, 1'b0);
        queue_number(31'd11, 1'b0);
        queue_number(31'd19, 1'b0);
        queue_number(31'd20, 1'b0);
        queue_number(31'd21, 1'b0);
        queue_number(31'd99, 1'b0);
        queue_number(31'd100, 1'b0);
        queue_number(31'd101, 1'b0);
        queue_number(31'd115, 1'b0);
        queue_number(31'd999, 1'b0);
        queue_number(31'd1000, 1'b0);
        queue_number(31'd1001, 1'b0);
        queue_number(31'd1000000, 1'b0);
        queue_number(31'd1000010, 1'b0);
        queue_number(31'd1000000000, 1'b0);
        queue_number(31'd2000000005, 1'b0);
        queue_number(31'd1777777777, 1'b0);
        queue_number(31'd1999999999, 1'b0);
        queue_number(VALUE_MAX, 1'b0);
        queue_number(31'd0, 1'b0);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            calm = ((i / 20) % 4 == 2);
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                sum = 64'($urandom) & 64'(VALUE_MAX);
            end else if (pick < 4) begin
                sum = 64'($urandom_range(0, 999));
            end else if (pick < 5) begin
                sum = 64'($urandom_range(0, 999999));
            end else begin
                // built from groups, some forced to zero
                grp_b = $urandom_range(0, 2);
                grp_m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 999);
                grp_t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 999);
                grp_u = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 999);
                sum = longint'(grp_b) * 1000000000 + longint'(grp_m) * 1000000
                    + longint'(grp_t) * 1000 + 64'(grp_u);
                if (sum > VALUE_MAX)
                    sum = sum - 1000000000;
            end
            queue_number(sum[30:0], calm);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (num_taken < total_items)
            @(posedge i_clk);
        while (word_code_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        run_done = 1'b1;

        $display("Spelled %0d numbers (edge values, zero groups, longest names) into %0d words,",
                 num_taken, words_taken);
        $display("with random gaps and stalls and a %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && word_code_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
